>>> rtl/mmv_pkg.sv
// Shared types and constants for the MAC merge verify handshake block.
// Item layouts, command and status codes, configuration register indexes.
// No dependencies.
package mmv_pkg;

  // Retry budget and clamp for the verify interval
  localparam logic [1:0] MAX_RETRIES     = 2'd3;
  localparam logic [7:0] MAX_VERIFY_MS   = 8'd128;
  localparam logic [7:0] VERIFY_TIME_RST = 8'd128;

  // Request types
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_LINK  = 3'd1;
  localparam logic [2:0] REQ_APPLY = 3'd2;
  localparam logic [2:0] REQ_STOP  = 3'd3;
  localparam logic [2:0] REQ_EVENT = 3'd4;

  // mPacket event codes
  localparam logic [1:0] EV_PARTNER_VERIFY   = 2'd0;
  localparam logic [1:0] EV_LOCAL_VERIFY     = 2'd1;
  localparam logic [1:0] EV_PARTNER_RESPONSE = 2'd2;

  // Commands
  localparam logic [1:0] SEND_NONE     = 2'd0;
  localparam logic [1:0] SEND_VERIFY   = 2'd1;
  localparam logic [1:0] SEND_RESPONSE = 2'd2;
  localparam logic [1:0] PMAC_NONE     = 2'd0;
  localparam logic [1:0] PMAC_DISABLE  = 2'd1;
  localparam logic [1:0] PMAC_ENABLE   = 2'd2;
  localparam logic [1:0] TX_NONE       = 2'd0;
  localparam logic [1:0] TX_DEACTIVATE = 2'd1;
  localparam logic [1:0] TX_ACTIVATE   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_VERIFY_ENABLE = 2'd0;
  localparam logic [1:0] CFG_PMAC_ENABLE   = 2'd1;
  localparam logic [1:0] CFG_TX_ENABLE     = 2'd2;
  localparam logic [1:0] CFG_VERIFY_TIME   = 2'd3;

  // Verify status
  typedef enum logic [2:0] {
    ST_DISABLED  = 3'd0,
    ST_INITIAL   = 3'd1,
    ST_VERIFYING = 3'd2,
    ST_SUCCEEDED = 3'd3,
    ST_FAILED    = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       port_up;
    logic [1:0] event_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0] mpkt_cmd;
    logic [1:0] pmac_cmd;
    logic [1:0] tx_cmd;
    logic [2:0] vstatus;
    logic       tx_live;
  } out_item_t;

  typedef struct packed {
    logic       verify_enable;
    logic       pmac_enable;
    logic       tx_enable;
    logic [7:0] verify_time_ms;
  } cfg_t;

  typedef struct packed {
    status_t    status;
    logic [1:0] retries_left;
    logic       timer_armed;
    logic [7:0] ticks_remaining;
  } vstate_t;

endpackage

>>> rtl/mac_merge_verify_fsm_core.sv
// Path: an accepted item is held in the input register, then takes one pass of step logic
// into the result register.
// Throughput: one item per cycle while the output is not stalled; state and result update together.
// Reset (rst, synchronous): status disabled, full retry budget, timer idle,
// config registers cleared with a verify interval of 128 ms, pipeline empty.
module mac_merge_verify_fsm_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mmv_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output mmv_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import mmv_pkg::*;

  cfg_t      cfg;
  vstate_t   state;
  vstate_t   state_next;
  in_item_t  item_reg;
  logic      item_full;
  logic      advance;
  out_item_t result;

  mmv_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mmv_step u_step (
    .cfg    (cfg),
    .cur    (state),
    .item   (item_reg),
    .nxt    (state_next),
    .result (result)
  );

  // Held item moves on when the result register is free or being drained
  assign advance  = item_full && (!out_valid || !out_stall);
  assign in_stall = item_full && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_full <= 1'b1;
    end else if (advance) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_reg <= in_item;
    end
  end

  // Handshake state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state.status          <= ST_DISABLED;
      state.retries_left    <= MAX_RETRIES;
      state.timer_armed     <= 1'b0;
      state.ticks_remaining <= 8'd0;
      out_valid             <= 1'b0;
    end else if (advance) begin
      state     <= state_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

`ifndef ASSERT_OFF
  a_retries_bound: assert property (@(posedge clk) disable iff (rst)
    state.retries_left <= MAX_RETRIES)
    else $error("retry count above budget");

  a_timer_count: assert property (@(posedge clk) disable iff (rst)
    state.timer_armed |-> (state.ticks_remaining != 8'd0 &&
                           state.ticks_remaining <= MAX_VERIFY_MS))
    else $error("armed timer holds an out-of-range count");

  a_armed_status: assert property (@(posedge clk) disable iff (rst)
    state.timer_armed |-> (state.status != ST_FAILED && state.status != ST_DISABLED))
    else $error("timer armed in failed or disabled status");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("state changed without an item");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !advance)
    else $error("result overwritten while stalled");
`endif

endmodule

>>> rtl/mmv_cfg.sv
// Configuration register file for the MAC merge verify block.
// Decodes the plain write port into the four control registers; uses mmv_pkg.
module mmv_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  output mmv_pkg::cfg_t cfg
);
  import mmv_pkg::*;

  // Register writes, one index per write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.verify_enable  <= 1'b0;
      cfg.pmac_enable    <= 1'b0;
      cfg.tx_enable      <= 1'b0;
      cfg.verify_time_ms <= VERIFY_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERIFY_ENABLE: cfg.verify_enable  <= cfg_data[0];
        CFG_PMAC_ENABLE:   cfg.pmac_enable    <= cfg_data[0];
        CFG_TX_ENABLE:     cfg.tx_enable      <= cfg_data[0];
        CFG_VERIFY_TIME:   cfg.verify_time_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/mmv_step.sv
// Next-state and result logic of the verify handshake for one item.
// Purely combinational; uses mmv_pkg types and codes.
module mmv_step (
  input  mmv_pkg::cfg_t     cfg,
  input  mmv_pkg::vstate_t  cur,
  input  mmv_pkg::in_item_t item,
  output mmv_pkg::vstate_t  nxt,
  output mmv_pkg::out_item_t result
);
  import mmv_pkg::*;

  logic [7:0] eff_time;
  logic [7:0] ticks_dec;
  logic [1:0] send;
  logic [1:0] pmac;
  logic [1:0] tx;

  // Clamp the verify interval into 1..MAX_VERIFY_MS
  always_comb begin
    if (cfg.verify_time_ms == 8'd0) begin
      eff_time = 8'd1;
    end else if (cfg.verify_time_ms > MAX_VERIFY_MS) begin
      eff_time = MAX_VERIFY_MS;
    end else begin
      eff_time = cfg.verify_time_ms;
    end
  end

  assign ticks_dec = (cur.ticks_remaining != 8'd0) ? cur.ticks_remaining - 8'd1
                                                   : cur.ticks_remaining;

  // Request decode and state update
  always_comb begin
    nxt  = cur;
    send = SEND_NONE;
    pmac = PMAC_NONE;
    tx   = TX_NONE;
    unique case (item.req_type)
      REQ_TICK: begin
        if (cur.timer_armed) begin
          nxt.ticks_remaining = ticks_dec;
          if (ticks_dec == 8'd0) begin
            nxt.timer_armed = 1'b0;
            // timer expiry
            if (cur.status == ST_INITIAL || cur.status == ST_VERIFYING) begin
              if (cur.retries_left != 2'd0) begin
                send                = SEND_VERIFY;
                nxt.timer_armed     = 1'b1;
                nxt.ticks_remaining = eff_time;
                nxt.retries_left    = cur.retries_left - 2'd1;
              end else begin
                nxt.status = ST_FAILED;
              end
            end else if (cur.status == ST_SUCCEEDED) begin
              tx = TX_ACTIVATE;
            end
          end
        end
      end
      REQ_LINK: begin
        nxt.timer_armed = 1'b0;
        if (item.port_up && cfg.pmac_enable) begin
          pmac = PMAC_ENABLE;
          if (!cfg.verify_enable) begin
            pmac = PMAC_ENABLE;
            tx   = cfg.tx_enable ? TX_ACTIVATE : TX_DEACTIVATE;
          end else begin
            nxt.status       = ST_INITIAL;
            nxt.retries_left = MAX_RETRIES;
            if (cfg.tx_enable) begin
              nxt.timer_armed     = 1'b1;
              nxt.ticks_remaining = 8'd1;
            end
          end
        end else begin
          if (cfg.verify_enable) begin
            nxt.status = ST_INITIAL;
          end
          pmac = PMAC_DISABLE;
          tx   = TX_DEACTIVATE;
        end
      end
      REQ_APPLY: begin
        nxt.timer_armed = 1'b0;
        if (!cfg.verify_enable) begin
          nxt.status = ST_DISABLED;
          pmac = cfg.pmac_enable ? PMAC_ENABLE : PMAC_DISABLE;
          tx   = cfg.tx_enable ? TX_ACTIVATE : TX_DEACTIVATE;
        end else begin
          nxt.status       = ST_INITIAL;
          nxt.retries_left = MAX_RETRIES;
          if (item.port_up && cfg.pmac_enable && cfg.tx_enable) begin
            nxt.timer_armed     = 1'b1;
            nxt.ticks_remaining = 8'd1;
          end
        end
      end
      REQ_STOP: begin
        nxt.timer_armed = 1'b0;
      end
      REQ_EVENT: begin
        if (cfg.pmac_enable) begin
          case (item.event_code)
            EV_PARTNER_VERIFY: send = SEND_RESPONSE;
            EV_LOCAL_VERIFY: begin
              if (cur.status != ST_SUCCEEDED) begin
                nxt.status = ST_VERIFYING;
              end
            end
            EV_PARTNER_RESPONSE: begin
              if (cur.status == ST_VERIFYING) begin
                nxt.status = ST_SUCCEEDED;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Result item reflects the status after the item
  always_comb begin
    result.mpkt_cmd = send;
    result.pmac_cmd = pmac;
    result.tx_cmd   = tx;
    result.vstatus  = nxt.status;
    result.tx_live  = cfg.tx_enable &&
                      (nxt.status == ST_SUCCEEDED || nxt.status == ST_DISABLED);
  end

endmodule
